/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset as disable.
`define PWN_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("pwn check failed");

// Same, with a caller-supplied message string.
`define PWN_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

`endif

/* src/pwn_pkg.sv */
// Shared types, constants and helper functions for the winding number block.
// Depends on nothing; imported by every module of the block.
package pwn_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int TOTAL_W        = 13;
	localparam int WIND_W         = TOTAL_W - 2;
	localparam int OUT_DATA_W     = ((WIND_W + 7) / 8) * 8;

	localparam logic signed [TOTAL_W:0] SUM_MAX = 14'sd4095;
	localparam logic signed [TOTAL_W:0] SUM_MIN = -14'sd4096;

	typedef logic [1:0] quad_t;

	localparam quad_t QUAD_I   = 2'd0;
	localparam quad_t QUAD_II  = 2'd1;
	localparam quad_t QUAD_III = 2'd2;
	localparam quad_t QUAD_IV  = 2'd3;

	typedef logic signed [2:0] delta_t;
	typedef logic signed [TOTAL_W-1:0] total_t;

	typedef struct packed {
		logic first;
		logic last;
	} item_flags_t;

	// Axis ties fall to the lower quadrant; the origin is quadrant I.
	function automatic quad_t quad_code(logic x_neg, logic x_zero, logic y_neg, logic y_zero);
		quad_t q;
		if (!x_neg && !y_neg) begin
			q = QUAD_I;
		end else if ((x_neg || x_zero) && !y_neg) begin
			q = QUAD_II;
		end else if (x_neg || x_zero || y_zero) begin
			q = QUAD_III;
		end else begin
			q = QUAD_IV;
		end
		return q;
	endfunction

	// Quadrant move along one edge; le is cross(next - this, this) <= 0.
	function automatic delta_t edge_delta(quad_t k, quad_t q, logic le);
		quad_t k_next;
		quad_t q_next;
		delta_t d;
		k_next = k + 2'd1;
		q_next = q + 2'd1;
		priority if (k == q) begin
			d = 3'sd0;
		end else if (q == k_next) begin
			d = 3'sd1;
		end else if (k == q_next) begin
			d = -3'sd1;
		end else if (le) begin
			d = 3'sd2;
		end else begin
			d = -3'sd2;
		end
		return d;
	endfunction

	function automatic total_t sat_add(total_t a, delta_t d);
		logic signed [TOTAL_W:0] s;
		total_t r;
		s = {a[TOTAL_W-1], a} + {{(TOTAL_W - 2){d[2]}}, d};
		if (s > SUM_MAX) begin
			s = SUM_MAX;
		end else if (s < SUM_MIN) begin
			s = SUM_MIN;
		end
		r = s[TOTAL_W-1:0];
		return r;
	endfunction

endpackage

/* src/polygon_winding_number.sv */
// Polygon winding number: vertices stream in one item per cycle while
// s_axis_tready is high; a result is registered once the last vertex has
// passed the pipeline. Depends on pwn_pkg, pwn_relq, pwn_cross and pwn_accum.
//
// One vertex is accepted every cycle while s_axis_tready is high. The item
// with tuser set latches the query point and opens a polygon; the item with
// tlast set closes it back to its first vertex and yields the winding number
// (quadrant total / 4, truncated toward zero). The last vertex passes the
// input, relative-position, cross-product and delta registers, then the
// running total and result register (m_axis_tvalid) update in the final
// stage. Vertices that are not last keep flowing while a result waits; the
// input stalls only when a last vertex waits there while the result register
// is still held, so s_axis_tready follows m_axis_tready combinationally.
module polygon_winding_number #(
	parameter int COORD_BITS = pwn_pkg::COORD_BITS_DEF,
	localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [IN_W-1:0]                  s_axis_tdata,  // vertex_x, vertex_y, query_x, query_y
	input  logic [0:0]                       s_axis_tuser,  // first_vertex
	input  logic                             s_axis_tlast,  // last_vertex
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pwn_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // winding
);
	import pwn_pkg::*;

	localparam int CB = COORD_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic en1, en2, en3, consume;
	logic out_free;

	item_flags_t flags_s1, flags_s2, flags_s3, flags_s4;
	logic signed [CB-1:0] vx_s1, vy_s1, qx_s1, qy_s1;
	logic signed [CB:0]   rel_x_s2, rel_y_s2;
	quad_t                quad_s2;
	delta_t               d1_s4, d2_s4;
	logic signed [WIND_W-1:0] winding;

	assign rdy4    = !vld_s4 || !flags_s4.last || out_free;
	assign rdy3    = !vld_s3 || rdy4;
	assign rdy2    = !vld_s2 || rdy3;
	assign rdy1    = !vld_s1 || rdy2;
	assign en1     = vld_s1 && rdy2;
	assign en2     = vld_s2 && rdy3;
	assign en3     = vld_s3 && rdy4;
	assign consume = vld_s4 && rdy4;

	assign s_axis_tready = rdy1;
	assign m_axis_tdata  = {{(OUT_DATA_W - WIND_W){1'b0}}, winding};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy1) begin
			vx_s1          <= s_axis_tdata[CB-1:0];
			vy_s1          <= s_axis_tdata[2*CB-1:CB];
			qx_s1          <= s_axis_tdata[3*CB-1:2*CB];
			qy_s1          <= s_axis_tdata[4*CB-1:3*CB];
			flags_s1.first <= s_axis_tuser[0];
			flags_s1.last  <= s_axis_tlast;
		end
		if (en1) begin
			flags_s2 <= flags_s1;
		end
		if (en2) begin
			flags_s3 <= flags_s2;
		end
		if (en3) begin
			flags_s4 <= flags_s3;
		end
	end

	pwn_relq #(
		.COORD_BITS(COORD_BITS)
	) u_relq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.flags_s1 (flags_s1),
		.vx_s1    (vx_s1),
		.vy_s1    (vy_s1),
		.qx_s1    (qx_s1),
		.qy_s1    (qy_s1),
		.rel_x_s2 (rel_x_s2),
		.rel_y_s2 (rel_y_s2),
		.quad_s2  (quad_s2)
	);

	pwn_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en2      (en2),
		.en3      (en3),
		.flags_s2 (flags_s2),
		.flags_s3 (flags_s3),
		.rel_x_s2 (rel_x_s2),
		.rel_y_s2 (rel_y_s2),
		.quad_s2  (quad_s2),
		.d1_s4    (d1_s4),
		.d2_s4    (d2_s4)
	);

	pwn_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.flags_s4  (flags_s4),
		.d1_s4     (d1_s4),
		.d2_s4     (d2_s4),
		.out_ready (m_axis_tready),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.winding   (winding)
	);

endmodule

/* src/pwn_relq.sv */
// Stage 2: latches the query point and forms the vertex relative to it,
// with its quadrant code. Depends on pwn_pkg.
module pwn_relq #(
	parameter int COORD_BITS = pwn_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  pwn_pkg::item_flags_t         flags_s1,
	input  logic signed [COORD_BITS-1:0] vx_s1,
	input  logic signed [COORD_BITS-1:0] vy_s1,
	input  logic signed [COORD_BITS-1:0] qx_s1,
	input  logic signed [COORD_BITS-1:0] qy_s1,
	output logic signed [COORD_BITS:0]   rel_x_s2,
	output logic signed [COORD_BITS:0]   rel_y_s2,
	output pwn_pkg::quad_t               quad_s2
);
	import pwn_pkg::*;

	logic signed [COORD_BITS-1:0] held_x_q;
	logic signed [COORD_BITS-1:0] held_y_q;
	logic signed [COORD_BITS-1:0] qx_eff;
	logic signed [COORD_BITS-1:0] qy_eff;
	logic signed [COORD_BITS:0]   rel_x;
	logic signed [COORD_BITS:0]   rel_y;

	assign qx_eff = flags_s1.first ? qx_s1 : held_x_q;
	assign qy_eff = flags_s1.first ? qy_s1 : held_y_q;
	assign rel_x  = {vx_s1[COORD_BITS-1], vx_s1} - {qx_eff[COORD_BITS-1], qx_eff};
	assign rel_y  = {vy_s1[COORD_BITS-1], vy_s1} - {qy_eff[COORD_BITS-1], qy_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (en && flags_s1.first) begin
			held_x_q <= qx_s1;
			held_y_q <= qy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_x_s2 <= rel_x;
			rel_y_s2 <= rel_y;
			quad_s2  <= quad_code(rel_x[COORD_BITS], rel_x == '0,
				rel_y[COORD_BITS], rel_y == '0);
		end
	end

endmodule

/* src/pwn_cross.sv */
// Stages 3 and 4: keeps prior and start vertices, forms the cross products
// of the chained and closing edges, then the quadrant deltas. Depends on pwn_pkg.
module pwn_cross #(
	parameter int COORD_BITS = pwn_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en2,
	input  logic                       en3,
	input  pwn_pkg::item_flags_t       flags_s2,
	input  pwn_pkg::item_flags_t       flags_s3,
	input  logic signed [COORD_BITS:0] rel_x_s2,
	input  logic signed [COORD_BITS:0] rel_y_s2,
	input  pwn_pkg::quad_t             quad_s2,
	output pwn_pkg::delta_t            d1_s4,
	output pwn_pkg::delta_t            d2_s4
);
	import pwn_pkg::*;

	localparam int PW = 2 * (COORD_BITS + 1);

	logic signed [COORD_BITS:0] prior_x_q;
	logic signed [COORD_BITS:0] prior_y_q;
	quad_t                      prior_quad_q;
	logic signed [COORD_BITS:0] start_x_q;
	logic signed [COORD_BITS:0] start_y_q;
	quad_t                      start_quad_q;

	logic signed [COORD_BITS:0] start_x_eff;
	logic signed [COORD_BITS:0] start_y_eff;
	quad_t                      start_quad_eff;

	logic signed [PW-1:0] p1a_s3;
	logic signed [PW-1:0] p1b_s3;
	logic signed [PW-1:0] p2a_s3;
	logic signed [PW-1:0] p2b_s3;
	quad_t                k1_s3;
	quad_t                q1_s3;
	quad_t                k2_s3;
	quad_t                q2_s3;

	// A first vertex closes onto itself when it is also the last.
	assign start_x_eff    = flags_s2.first ? rel_x_s2 : start_x_q;
	assign start_y_eff    = flags_s2.first ? rel_y_s2 : start_y_q;
	assign start_quad_eff = flags_s2.first ? quad_s2  : start_quad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_x_q    <= '0;
			prior_y_q    <= '0;
			prior_quad_q <= QUAD_I;
			start_x_q    <= '0;
			start_y_q    <= '0;
			start_quad_q <= QUAD_I;
		end else if (en2) begin
			prior_x_q    <= rel_x_s2;
			prior_y_q    <= rel_y_s2;
			prior_quad_q <= quad_s2;
			if (flags_s2.first) begin
				start_x_q    <= rel_x_s2;
				start_y_q    <= rel_y_s2;
				start_quad_q <= quad_s2;
			end
		end
	end

	// cross(n - t, t) <= 0  <=>  nx*ty <= ny*tx
	always_ff @(posedge clk) begin
		if (en2) begin
			p1a_s3 <= rel_x_s2 * prior_y_q;
			p1b_s3 <= rel_y_s2 * prior_x_q;
			p2a_s3 <= start_x_eff * rel_y_s2;
			p2b_s3 <= start_y_eff * rel_x_s2;
			k1_s3  <= prior_quad_q;
			q1_s3  <= quad_s2;
			k2_s3  <= quad_s2;
			q2_s3  <= start_quad_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			d1_s4 <= flags_s3.first ? 3'sd0 : edge_delta(k1_s3, q1_s3, p1a_s3 <= p1b_s3);
			d2_s4 <= flags_s3.last ? edge_delta(k2_s3, q2_s3, p2a_s3 <= p2b_s3) : 3'sd0;
		end
	end

endmodule

/* src/pwn_accum.sv */
// Final stage: saturating running total, divide by four toward zero,
// and the result register. Depends on pwn_pkg.
module pwn_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                consume,
	input  pwn_pkg::item_flags_t                flags_s4,
	input  pwn_pkg::delta_t                     d1_s4,
	input  pwn_pkg::delta_t                     d2_s4,
	input  logic                                out_ready,
	output logic                                out_free,
	output logic                                out_valid,
	output logic signed [pwn_pkg::WIND_W-1:0]   winding
);
	import pwn_pkg::*;

	total_t total_q;
	total_t t0;
	total_t t1;
	total_t t2;
	total_t adj;
	logic   out_valid_q;
	logic signed [WIND_W-1:0] winding_q;

	assign t0  = flags_s4.first ? '0 : total_q;
	assign t1  = sat_add(t0, d1_s4);
	assign t2  = sat_add(t1, d2_s4);
	assign adj = t2 + {{(TOTAL_W - 2){1'b0}}, {2{t2[TOTAL_W-1]}}};

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign winding   = winding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (consume) begin
				total_q <= flags_s4.last ? '0 : t2;
			end
			if (consume && flags_s4.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && flags_s4.last) begin
			winding_q <= adj[TOTAL_W-1:2];
		end
	end

endmodule

/* src/pwn_checker.sv */
// Port-level checks for polygon_winding_number, bound to the top level.
// Depends on pwn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwn_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [pwn_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import pwn_pkg::*;

	// Last vertices taken but whose result is not yet delivered.
	logic [2:0] pend_q;
	logic       in_last;
	logic       out_take;
	logic       out_stall;

	assign in_last   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_take  = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_last && !out_take) begin
			pend_q <= pend_q + 3'd1;
		end else if (!in_last && out_take) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	`PWN_ASSERT_MSG(a_out_hold, clk, arst_n,
		out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`PWN_ASSERT_MSG(a_no_invented, clk, arst_n,
		m_axis_tvalid |-> pend_q != 3'd0, "result without a pending last vertex")
	`PWN_ASSERT_MSG(a_pend_bound, clk, arst_n,
		pend_q <= 3'd5, "more pending polygons than pipeline slots")
	`PWN_ASSERT_MSG(a_stall_cause, clk, arst_n,
		!s_axis_tready |-> out_stall, "input stalled while result side free")
	`PWN_ASSERT(a_pad_zero, clk, arst_n,
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:WIND_W] == '0)

endmodule

bind polygon_winding_number pwn_checker u_pwn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* bench/polygon_winding_number_test.sv */
// Testbench for polygon_winding_number: vertex streams in, winding numbers out,
// each result checked against a quadrant-counting predictor kept in the bench.
// Depends on pwn_pkg and the polygon_winding_number RTL.
`timescale 1ns / 1ps

module polygon_winding_number_test;
	import pwn_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 60000;
	localparam int DRAIN_CYCLES = 16;
	localparam int TOTAL_TOP = 4095;
	localparam int TOTAL_BOTTOM = -4096;

	localparam int RX_OPEN = 0;
	localparam int RX_COIN = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_ALTERNATE = 3;

	localparam int SHAPE_WOUND = 0;
	localparam int SHAPE_SCATTER = 1;
	localparam int SHAPE_TIGHT = 2;
	localparam int SHAPE_CHAINED = 3;
	localparam int SHAPE_NOISE = 4;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [CW:0] rel_t;
	typedef logic signed [WIND_W-1:0] wind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [4*CW-1:0] s_axis_tdata = '0;  // vertex_x, vertex_y, query_x, query_y
	logic [0:0] s_axis_tuser = 1'b0;     // first_vertex
	logic s_axis_tlast = 1'b0;           // last_vertex
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata; // winding

	polygon_winding_number DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	// predictor state
	coord_t held_qx = '0, held_qy = '0;
	rel_t start_x = '0, start_y = '0, prior_x = '0, prior_y = '0;
	quad_t start_q = QUAD_I, prior_q = QUAD_I;
	int winding_total = 0;
	wind_t winding_expected[$];

	int fail_count = 0;
	int vertices_sent = 0;
	int windings_expected = 0;
	int windings_checked = 0;
	int clamp_events = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;
	wind_t wind_exp;

	// sender idling
	bit idle_on = 1'b1;
	int burst_left = 0;

	// receiver stall pattern and long hold request
	int hold_seq = 0;
	int hold_len = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int longest_hold = 0;
	int rx_mode = RX_OPEN;
	int rx_left = 0;
	bit rx_phase = 1'b0;

	function automatic quad_t quadrant_of(rel_t x, rel_t y);
		if (x >= 0 && y >= 0)
			return QUAD_I;
		if (x <= 0 && y >= 0)
			return QUAD_II;
		if (x <= 0)
			return QUAD_III;
		return QUAD_IV;
	endfunction

	// change of quadrant total along the edge from (tx,ty) to (nx,ny)
	function automatic int quadrant_step(rel_t tx, rel_t ty, quad_t k, rel_t nx, rel_t ny,
			quad_t q);
		if (k == q)
			return 0;
		if (q == quad_t'(k + 2'd1))
			return 1;
		if (k == quad_t'(q + 2'd1))
			return -1;
		// diagonal: sign from cross(next - this, this), zero counts positive
		if (longint'(nx) * longint'(ty) <= longint'(ny) * longint'(tx))
			return 2;
		return -2;
	endfunction

	function automatic void add_step(int d);
		int t;
		t = winding_total + d;
		if (t > TOTAL_TOP) begin
			t = TOTAL_TOP;
			clamp_events++;
		end else if (t < TOTAL_BOTTOM) begin
			t = TOTAL_BOTTOM;
			clamp_events++;
		end
		winding_total = t;
	endfunction

	function automatic void track_vertex(coord_t vx, coord_t vy, coord_t qx, coord_t qy,
			bit is_first, bit is_last);
		rel_t rx, ry;
		quad_t q;
		if (is_first) begin
			held_qx = qx;
			held_qy = qy;
		end
		rx = rel_t'(vx) - rel_t'(held_qx);
		ry = rel_t'(vy) - rel_t'(held_qy);
		q = quadrant_of(rx, ry);
		if (is_first) begin
			start_x = rx;
			start_y = ry;
			start_q = q;
			winding_total = 0;
		end else begin
			add_step(quadrant_step(prior_x, prior_y, prior_q, rx, ry, q));
		end
		prior_x = rx;
		prior_y = ry;
		prior_q = q;
		if (is_last) begin
			add_step(quadrant_step(rx, ry, q, start_x, start_y, start_q));
			winding_expected.push_back(wind_t'(winding_total / 4));
			winding_total = 0;
			windings_expected++;
		end
	endfunction

	// query fields carry noise unless the item opens a polygon
	task automatic send_vertex(coord_t vx, coord_t vy, coord_t qx, coord_t qy,
			bit is_first, bit is_last);
		coord_t qx_drive, qy_drive;
		int gap;
		qx_drive = is_first ? qx : coord_t'($urandom);
		qy_drive = is_first ? qy : coord_t'($urandom);
		if (idle_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {$urandom, $urandom, $urandom};
			s_axis_tuser <= 1'($urandom);
			s_axis_tlast <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tdata <= {qy_drive, qx_drive, vy, vx};
		s_axis_tuser <= is_first;
		s_axis_tlast <= is_last;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		vertices_sent++;
		track_vertex(vx, vy, qx_drive, qy_drive, is_first, is_last);
	endtask

	function automatic void point_in_quadrant(int qd, int lo, int hi, output coord_t rx,
			output coord_t ry);
		rx = coord_t'($urandom_range(lo, hi));
		ry = coord_t'($urandom_range(lo, hi));
		if (qd == 1 || qd == 2)
			rx = -rx;
		if (qd == 2 || qd == 3)
			ry = -ry;
	endfunction

	// no first marker yet: chain runs from the all-zero reset state
	task automatic test_chain_from_reset();
		send_vertex(-256, 256, 0, 0, 1'b0, 1'b0);
		send_vertex(-256, -256, 0, 0, 1'b0, 1'b0);
		send_vertex(256, -256, 0, 0, 1'b0, 1'b0);
		send_vertex(256, 256, 0, 0, 1'b0, 1'b1);
	endtask

	task automatic test_single_vertex();
		send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b1, 1'b1);
		send_vertex(0, 0, 0, 0, 1'b1, 1'b1);
	endtask

	task automatic test_squares();
		coord_t qx, qy;
		qx = 1000;
		qy = -2000;
		send_vertex(qx + 500, qy + 500, qx, qy, 1'b1, 1'b0);
		send_vertex(qx - 500, qy + 500, qx, qy, 1'b0, 1'b0);
		send_vertex(qx - 500, qy - 500, qx, qy, 1'b0, 1'b0);
		send_vertex(qx + 500, qy - 500, qx, qy, 1'b0, 1'b1);
		send_vertex(qx + 500, qy - 500, qx, qy, 1'b1, 1'b0);
		send_vertex(qx - 500, qy - 500, qx, qy, 1'b0, 1'b0);
		send_vertex(qx - 500, qy + 500, qx, qy, 1'b0, 1'b0);
		send_vertex(qx + 500, qy + 500, qx, qy, 1'b0, 1'b1);
	endtask

	// after a result the chain goes on from the emitted vertex and old start
	task automatic test_continue_after_result();
		send_vertex(500, -2500, 0, 0, 1'b0, 1'b0);
		send_vertex(-1500, -1500, 0, 0, 1'b0, 1'b1);
	endtask

	task automatic test_axis_ties();
		send_vertex(40, -40, 40, -40, 1'b1, 1'b0);
		send_vertex(40, -35, 40, -40, 1'b0, 1'b0);
		send_vertex(35, -40, 40, -40, 1'b0, 1'b0);
		send_vertex(40, -45, 40, -40, 1'b0, 1'b1);
	endtask

	// collinear diagonal jump (zero cross product) and a negative one
	task automatic test_diagonal_jumps();
		send_vertex(10, 10, 7, 7, 1'b1, 1'b0);
		send_vertex(1, 1, 7, 7, 1'b0, 1'b0);
		send_vertex(9, 11, 7, 7, 1'b0, 1'b1);
	endtask

	task automatic test_extremes();
		send_vertex(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0);
		send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0);
		send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b1);
	endtask

	// receiver holds off while short polygons keep coming; input must stall
	task automatic test_output_hold();
		int n;
		idle_on = 1'b0;
		hold_len <= 240;
		hold_seq <= hold_seq + 1;
		for (int p = 0; p < 40; p++) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), i == 0, i == n - 1);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random(int target);
		int base, r, shape, n, turns, dir, qd, m;
		coord_t qx, qy, rx, ry;
		base = vertices_sent;
		while (vertices_sent - base < target) begin
			if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			r = $urandom_range(0, 19);
			shape = r < 9 ? SHAPE_WOUND : r < 14 ? SHAPE_SCATTER : r < 17 ? SHAPE_TIGHT :
				r < 19 ? SHAPE_CHAINED : SHAPE_NOISE;
			qx = coord_t'(int'($urandom_range(0, 8388608)) - 4194304);
			qy = coord_t'(int'($urandom_range(0, 8388608)) - 4194304);
			case (shape)
				SHAPE_WOUND: begin
					turns = $urandom_range(0, 3);
					n = 4 * turns + $urandom_range(1, 4);
					dir = $urandom_range(0, 1) ? 1 : 3;
					qd = $urandom_range(0, 3);
					m = 1 << $urandom_range(0, 21);
					for (int i = 0; i < n; i++) begin
						point_in_quadrant(qd, $urandom_range(0, 1), m, rx, ry);
						send_vertex(qx + rx, qy + ry, qx, qy, i == 0, i == n - 1);
						qd = (qd + dir + ($urandom_range(0, 9) == 0 ? dir : 0)) % 4;
					end
				end
				SHAPE_SCATTER: begin
					n = $urandom_range(1, 10);
					for (int i = 0; i < n; i++)
						send_vertex(coord_t'($urandom), coord_t'($urandom),
							coord_t'($urandom), coord_t'($urandom), i == 0, i == n - 1);
				end
				SHAPE_TIGHT: begin
					n = $urandom_range(1, 8);
					for (int i = 0; i < n; i++)
						send_vertex(qx + int'($urandom_range(0, 6)) - 3,
							qy + int'($urandom_range(0, 6)) - 3, qx, qy, i == 0, i == n - 1);
				end
				SHAPE_CHAINED: begin
					n = $urandom_range(1, 6);
					m = 1 << $urandom_range(0, 22);
					for (int i = 0; i < n; i++)
						send_vertex(held_qx + int'($urandom_range(0, 2 * m)) - m,
							held_qy + int'($urandom_range(0, 2 * m)) - m, qx, qy, 1'b0,
							i == n - 1);
				end
				default: begin
					send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), 1'($urandom), 1'($urandom));
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
			if (hold_len > longest_hold)
				longest_hold = hold_len;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_OPEN, RX_ALTERNATE);
			rx_left = $urandom_range(10, 150);
		end
		rx_left--;
		rx_phase = !rx_phase;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: m_axis_tready <= 1'b1;
				RX_COIN: m_axis_tready <= 1'($urandom);
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= rx_phase;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("FAIL polygon_winding_number");
			$finish;
		end
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			input_stall_cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (winding_expected.size() == 0) begin
				$display("%0t: winding %0d with none expected", $time,
					$signed(m_axis_tdata[WIND_W-1:0]));
				fail_count++;
			end else begin
				wind_exp = winding_expected.pop_front();
				windings_checked++;
				if (m_axis_tdata[WIND_W-1:0] !== wind_exp) begin
					$display("%0t: winding mismatch, expected %0d, actual %0d", $time,
						wind_exp, $signed(m_axis_tdata[WIND_W-1:0]));
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_chain_from_reset();
		test_single_vertex();
		test_squares();
		test_continue_after_result();
		test_axis_ties();
		test_diagonal_jumps();
		test_extremes();
		test_output_hold();
		test_random(880);
		s_axis_tvalid <= 1'b0;
		while (winding_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d vertices, checked %0d of %0d windings; total clamped %0d times.",
			vertices_sent, windings_checked, windings_expected, clamp_events);
		$display("Input stalled %0d cycles; longest receiver hold %0d cycles.",
			input_stall_cycles, longest_hold);
		if (fail_count == 0 && winding_expected.size() == 0) begin
			$display("PASS polygon_winding_number");
		end else begin
			$display("FAIL polygon_winding_number");
		end
		$finish;
	end

endmodule
